// ===== design/tpi_pkg.sv =====
// Shared types, constants and arithmetic helpers for the trackpad report and glide engine.
package tpi_pkg;

    // Widths of the datapath.
    localparam int DELTA_W    = 16;
    localparam int AMT_W      = 16;
    localparam int VEL_W      = 26;
    localparam int FRAC_W     = 8;
    localparam int STEP_W     = 19;
    localparam int SCROLL_W   = DELTA_W + 1;
    localparam int WHEEL_DIV  = 32;
    localparam int ACC_W      = $clog2(WHEEL_DIV) + 1;
    localparam int FRICTION_W = 8;
    localparam int MIN_SPD_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [STEP_W:0] WHEEL_DIV_S = (STEP_W + 1)'(WHEEL_DIV);

    localparam logic [FRICTION_W-1:0] FRICTION_RESET  = 8'd242;
    localparam logic [MIN_SPD_W-1:0]  MIN_SPEED_RESET = 6'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ALLOWED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ALLOWED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_Y      = 3'd6;

    typedef enum logic [2:0] {
        EV_CURSOR_X    = 3'd0,
        EV_CURSOR_Y    = 3'd1,
        EV_HWHEEL      = 3'd2,
        EV_WHEEL       = 3'd3,
        EV_TAP_PRESS   = 3'd4,
        EV_HOLD_PRESS  = 3'd5,
        EV_HOLD_RELEAS = 3'd6,
        EV_RESET_ACK   = 3'd7
    } event_code_t;

    typedef enum logic [1:0] {
        GLIDE_NONE   = 2'd0,
        GLIDE_CURSOR = 2'd1,
        GLIDE_SCROLL = 2'd2
    } glide_kind_t;

    typedef struct packed {
        logic                  glide_enable;
        logic                  glide_cursor_allowed;
        logic                  glide_scroll_allowed;
        logic [FRICTION_W-1:0] friction_retained;
        logic [MIN_SPD_W-1:0]  min_glide_speed;
        logic                  natural_x;
        logic                  natural_y;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic                      reset_seen;
        logic                      tap_one;
        logic                      tap_two;
        logic                      hold_flag;
        logic                      scroll_flag;
        logic                      moved_flag;
        logic [7:0]                finger_count;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } item_t;

    typedef struct packed {
        event_code_t             code;
        logic signed [AMT_W-1:0] amount;
    } event_t;

    typedef struct packed {
        logic [1:0] count;
        event_t     first;
        event_t     second;
    } ev_pair_t;

    typedef struct packed {
        logic                    fire;
        logic signed [AMT_W-1:0] steps;
        logic signed [ACC_W-1:0] rem;
    } wheel_t;

    // Clamp a wide signed value into the 16-bit amount range.
    function automatic logic signed [AMT_W-1:0] sat16(input logic signed [STEP_W:0] v);
        logic signed [STEP_W:0] hi;
        logic signed [STEP_W:0] lo;
        hi = (STEP_W + 1)'(32767);
        lo = -(STEP_W + 1)'(32768);
        if (v > hi) begin
            return 16'sh7FFF;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[AMT_W-1:0];
    endfunction

    // Add a delta to a wheel remainder and split off whole steps, truncating toward zero.
    function automatic wheel_t wheel_step(input logic signed [ACC_W-1:0] acc,
                                          input logic signed [STEP_W-1:0] delta);
        logic signed [STEP_W:0] sum;
        logic signed [STEP_W:0] quo;
        logic signed [STEP_W:0] rem;
        wheel_t r;
        sum    = (STEP_W + 1)'(acc) + (STEP_W + 1)'(delta);
        quo    = sum / WHEEL_DIV_S;
        rem    = sum % WHEEL_DIV_S;
        r.fire  = (quo != '0);
        r.steps = sat16(quo);
        r.rem   = rem[ACC_W-1:0];
        return r;
    endfunction

    // Three-quarter exponential average in Q8: floor((3v + s * 256) / 4).
    function automatic logic signed [VEL_W-1:0] vel_ema(input logic signed [VEL_W-1:0] v,
                                                       input logic signed [SCROLL_W-1:0] s);
        logic signed [VEL_W+1:0] v28;
        logic signed [VEL_W+1:0] s28;
        logic signed [VEL_W+1:0] t;
        v28 = (VEL_W + 2)'(v);
        s28 = (VEL_W + 2)'(s);
        t   = v28 + (v28 <<< 1) + (s28 <<< 8);
        return $signed(t[VEL_W+1:2]);
    endfunction

endpackage

// ===== design/tpi_cfg_regs.sv =====
// Configuration register file of the trackpad glide engine.
module tpi_cfg_regs
    import tpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GLIDE_ENABLE:   cfg_next.glide_enable         = cfg_data[0];
                CFG_CURSOR_ALLOWED: cfg_next.glide_cursor_allowed = cfg_data[0];
                CFG_SCROLL_ALLOWED: cfg_next.glide_scroll_allowed = cfg_data[0];
                CFG_FRICTION:       cfg_next.friction_retained    = cfg_data[FRICTION_W-1:0];
                CFG_MIN_SPEED:      cfg_next.min_glide_speed      = cfg_data[MIN_SPD_W-1:0];
                CFG_NATURAL_X:      cfg_next.natural_x            = cfg_data[0];
                CFG_NATURAL_Y:      cfg_next.natural_y            = cfg_data[0];
                default:            cfg_next                      = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{glide_enable: 1'b0, glide_cursor_allowed: 1'b0,
                         glide_scroll_allowed: 1'b0, friction_retained: FRICTION_RESET,
                         min_glide_speed: MIN_SPEED_RESET, natural_x: 1'b0,
                         natural_y: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/tpi_engine.sv =====
// Glide and gesture state with the single-pass datapath that turns one item into events.
module tpi_engine
    import tpi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  item_t    item,
    input  cfg_t     cfg,
    output ev_pair_t events
);

    logic signed [VEL_W-1:0] vel_x_reg, vel_x_next;
    logic signed [VEL_W-1:0] vel_y_reg, vel_y_next;
    logic [FRAC_W-1:0]       frac_x_reg, frac_x_next;
    logic [FRAC_W-1:0]       frac_y_reg, frac_y_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    glide_kind_t             kind_reg, kind_next;
    logic                    armed_reg, armed_next;
    logic                    touch_reg, touch_next;
    logic                    hold_reg, hold_next;

    // Glide replay: fraction plus velocity, whole counts from bit 8 upward.
    logic signed [VEL_W:0]     fsum_x, fsum_y;
    logic signed [STEP_W-1:0]  sx, sy;
    logic signed [VEL_W+8:0]   dprod_x, dprod_y;
    logic signed [VEL_W-1:0]   dvel_x, dvel_y;
    logic                      slow;
    logic signed [VEL_W:0]     minq;
    logic                      fast;
    logic                      glide_ok;
    logic                      touching;
    logic signed [SCROLL_W-1:0] s_x, s_y;
    wheel_t                    wtx, wty;

    assign fsum_x  = $signed({{(VEL_W + 1 - FRAC_W){1'b0}}, frac_x_reg}) + (VEL_W + 1)'(vel_x_reg);
    assign fsum_y  = $signed({{(VEL_W + 1 - FRAC_W){1'b0}}, frac_y_reg}) + (VEL_W + 1)'(vel_y_reg);
    assign sx      = fsum_x[VEL_W:FRAC_W];
    assign sy      = fsum_y[VEL_W:FRAC_W];

    assign dprod_x = (VEL_W + 9)'(vel_x_reg) *
                     (VEL_W + 9)'($signed({1'b0, cfg.friction_retained}));
    assign dprod_y = (VEL_W + 9)'(vel_y_reg) *
                     (VEL_W + 9)'($signed({1'b0, cfg.friction_retained}));
    assign dvel_x  = dprod_x[VEL_W+7:8];
    assign dvel_y  = dprod_y[VEL_W+7:8];
    assign slow    = (dvel_x > -26'sd256) && (dvel_x < 26'sd256) &&
                     (dvel_y > -26'sd256) && (dvel_y < 26'sd256);

    assign minq = $signed({{(VEL_W + 1 - MIN_SPD_W - 8){1'b0}}, cfg.min_glide_speed, 8'b0});
    assign fast = ((VEL_W + 1)'(vel_x_reg) >= minq) || ((VEL_W + 1)'(vel_x_reg) <= -minq) ||
                  ((VEL_W + 1)'(vel_y_reg) >= minq) || ((VEL_W + 1)'(vel_y_reg) <= -minq);
    assign glide_ok = cfg.glide_enable &&
                      ((kind_reg == GLIDE_CURSOR && cfg.glide_cursor_allowed) ||
                       (kind_reg == GLIDE_SCROLL && cfg.glide_scroll_allowed));

    assign touching = (item.finger_count != 8'd0);
    assign s_x      = cfg.natural_x ? SCROLL_W'(item.delta_x) : -SCROLL_W'(item.delta_x);
    assign s_y      = cfg.natural_y ? -SCROLL_W'(item.delta_y) : SCROLL_W'(item.delta_y);

    assign wtx = wheel_step(acc_x_reg, sx);
    assign wty = wheel_step(acc_y_reg, sy);

    always_comb begin
        wheel_t wr;
        vel_x_next  = vel_x_reg;
        vel_y_next  = vel_y_reg;
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        kind_next   = kind_reg;
        armed_next  = armed_reg;
        touch_next  = touch_reg;
        hold_next   = hold_reg;
        events      = '0;
        wr          = '0;

        if (item.kind) begin
            if (armed_reg) begin
                if (kind_reg != GLIDE_CURSOR && kind_reg != GLIDE_SCROLL) begin
                    armed_next = 1'b0;
                end else begin
                    frac_x_next = fsum_x[FRAC_W-1:0];
                    frac_y_next = fsum_y[FRAC_W-1:0];
                    if (kind_reg == GLIDE_CURSOR) begin
                        if (sx != '0 || sy != '0) begin
                            events.count  = 2'd2;
                            events.first  = '{code: EV_CURSOR_X, amount: sat16((STEP_W + 1)'(sx))};
                            events.second = '{code: EV_CURSOR_Y, amount: sat16((STEP_W + 1)'(sy))};
                        end
                    end else begin
                        // A remainder is always below one step, so adding zero never fires.
                        acc_x_next = wtx.rem;
                        acc_y_next = wty.rem;
                        if (wtx.fire) begin
                            events.count = 2'd1;
                            events.first = '{code: EV_HWHEEL, amount: wtx.steps};
                        end
                        if (wty.fire) begin
                            if (wtx.fire) begin
                                events.count  = 2'd2;
                                events.second = '{code: EV_WHEEL, amount: wty.steps};
                            end else begin
                                events.count = 2'd1;
                                events.first = '{code: EV_WHEEL, amount: wty.steps};
                            end
                        end
                    end
                    vel_x_next = dvel_x;
                    vel_y_next = dvel_y;
                    if (slow) begin
                        kind_next   = GLIDE_NONE;
                        vel_x_next  = '0;
                        vel_y_next  = '0;
                        frac_x_next = '0;
                        frac_y_next = '0;
                        armed_next  = 1'b0;
                    end
                end
            end
        end else if (item.reset_seen) begin
            events.count = 2'd1;
            events.first = '{code: EV_RESET_ACK, amount: '0};
        end else begin
            if (!item.scroll_flag) begin
                acc_x_next = '0;
                acc_y_next = '0;
            end
            if (touching && !touch_reg) begin
                armed_next  = 1'b0;
                kind_next   = GLIDE_NONE;
                vel_x_next  = '0;
                vel_y_next  = '0;
                frac_x_next = '0;
                frac_y_next = '0;
                acc_x_next  = '0;
                acc_y_next  = '0;
            end else if (!touching && touch_reg) begin
                if (glide_ok && fast) begin
                    frac_x_next = '0;
                    frac_y_next = '0;
                    armed_next  = 1'b1;
                end else begin
                    kind_next  = GLIDE_NONE;
                    vel_x_next = '0;
                    vel_y_next = '0;
                end
            end
            touch_next = touching;

            priority if (item.hold_flag && !hold_reg) begin
                events.count = 2'd1;
                events.first = '{code: EV_HOLD_PRESS, amount: '0};
                hold_next    = 1'b1;
                kind_next    = GLIDE_NONE;
                vel_x_next   = '0;
                vel_y_next   = '0;
            end else if (!item.hold_flag && hold_reg) begin
                events.count = 2'd1;
                events.first = '{code: EV_HOLD_RELEAS, amount: '0};
                hold_next    = 1'b0;
                kind_next    = GLIDE_NONE;
                vel_x_next   = '0;
                vel_y_next   = '0;
            end else if (item.tap_one) begin
                events.count = 2'd1;
                events.first = '{code: EV_TAP_PRESS, amount: 16'sd0};
            end else if (item.tap_two) begin
                events.count = 2'd1;
                events.first = '{code: EV_TAP_PRESS, amount: 16'sd1};
            end else if (item.scroll_flag) begin
                // Only the horizontal axis counts when it moved at all.
                if (item.delta_x != '0) begin
                    wr         = wheel_step(acc_x_next, STEP_W'(s_x));
                    acc_x_next = wr.rem;
                    if (wr.fire) begin
                        events.count = 2'd1;
                        events.first = '{code: EV_HWHEEL, amount: wr.steps};
                    end
                    vel_x_next = vel_ema(vel_x_next, s_x);
                    vel_y_next = vel_ema(vel_y_next, '0);
                    kind_next  = GLIDE_SCROLL;
                end else if (item.delta_y != '0) begin
                    wr         = wheel_step(acc_y_next, STEP_W'(s_y));
                    acc_y_next = wr.rem;
                    if (wr.fire) begin
                        events.count = 2'd1;
                        events.first = '{code: EV_WHEEL, amount: wr.steps};
                    end
                    vel_y_next = vel_ema(vel_y_next, s_y);
                    vel_x_next = vel_ema(vel_x_next, '0);
                    kind_next  = GLIDE_SCROLL;
                end
            end else if (item.moved_flag) begin
                if (item.delta_x != '0 || item.delta_y != '0) begin
                    events.count  = 2'd2;
                    events.first  = '{code: EV_CURSOR_X, amount: item.delta_x};
                    events.second = '{code: EV_CURSOR_Y, amount: item.delta_y};
                end
                vel_x_next = vel_ema(vel_x_next, SCROLL_W'(item.delta_x));
                vel_y_next = vel_ema(vel_y_next, SCROLL_W'(item.delta_y));
                kind_next  = GLIDE_CURSOR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_x_reg  <= '0;
            vel_y_reg  <= '0;
            frac_x_reg <= '0;
            frac_y_reg <= '0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
            kind_reg   <= GLIDE_NONE;
            armed_reg  <= 1'b0;
            touch_reg  <= 1'b0;
            hold_reg   <= 1'b0;
        end else if (step_en) begin
            vel_x_reg  <= vel_x_next;
            vel_y_reg  <= vel_y_next;
            frac_x_reg <= frac_x_next;
            frac_y_reg <= frac_y_next;
            acc_x_reg  <= acc_x_next;
            acc_y_reg  <= acc_y_next;
            kind_reg   <= kind_next;
            armed_reg  <= armed_next;
            touch_reg  <= touch_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

// ===== design/tpi_out_buf.sv =====
// Two-entry event buffer that hands the events of one item out one word at a time.
module tpi_out_buf
    import tpi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ev_pair_t         events,
    output logic             load_ok,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [AMT_W-1:0] m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic [1:0] count_reg, count_next;
    event_t     head_reg, head_next;
    event_t     tail_reg, tail_next;
    logic       take;

    assign m_tvalid = (count_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    // A new item may land when the buffer is empty or its final word leaves now.
    assign load_ok  = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign m_tdata  = head_reg.amount;
    assign m_tuser  = head_reg.code;
    assign m_tlast  = (count_reg == 2'd1);

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (load) begin
            count_next = events.count;
            head_next  = events.first;
            tail_next  = events.second;
        end else if (take) begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> load_ok)
        else $error("event buffer loaded while words were still pending");

    a_pair_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && events.count == 2'd2) |=> (m_tvalid && !m_tlast))
        else $error("first word of a pair flagged as last");

    a_shift_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && count_reg == 2'd2 && !load) |=>
            (count_reg == 2'd1 && m_tuser == $past(tail_reg.code)))
        else $error("second word of a pair not moved to the head");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("event buffer count out of range");

endmodule

// ===== design/trackpad_report_inertia_core.sv =====
// Top level of the trackpad report and glide engine.
//
//  Channel   Ports              Word contents
//  input     s_tvalid/s_tready  one trackpad report or glide tick
//  output    m_tvalid/m_tready  one cursor, wheel, button or acknowledge event
//  config    cfg_valid/ready    register index and value
//
//  An item waits in the input register and is processed in a single pass
//  into the event buffer, so the block takes an item every cycle while the buffer can load.
//  Each item gives zero, one or two events; the output sends one event per cycle while
//  m_tready is high, so after an item with two events the next one waits in the input register.
//  A stall on the output backs up into s_tready once the buffer and input register are full.
//  Reset is synchronous, active low, and returns glide state, config and valid flags to defaults.
module trackpad_report_inertia_core
    import tpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // reset_seen, tap_one, tap_two, hold_flag, scroll_flag, moved_flag,
    // finger_count[13:6], delta_x[29:14], delta_y[45:30], zero pad [47:46]
    input  logic [47:0]           s_tdata,
    // kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // amount
    output logic [AMT_W-1:0]      m_tdata,
    // event code
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    item_t    item_reg, item_next;
    logic     item_valid_reg, item_valid_next;
    logic     load_ok;
    logic     advance;
    logic     s_take;
    cfg_t     cfg;
    ev_pair_t events;

    assign advance  = item_valid_reg && load_ok;
    assign s_tready = !item_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        item_next.kind         = s_tuser;
        item_next.reset_seen   = s_tdata[0];
        item_next.tap_one      = s_tdata[1];
        item_next.tap_two      = s_tdata[2];
        item_next.hold_flag    = s_tdata[3];
        item_next.scroll_flag  = s_tdata[4];
        item_next.moved_flag   = s_tdata[5];
        item_next.finger_count = s_tdata[13:6];
        item_next.delta_x      = $signed(s_tdata[29:14]);
        item_next.delta_y      = $signed(s_tdata[45:30]);

        item_valid_next = item_valid_reg;
        if (s_take) begin
            item_valid_next = 1'b1;
        end else if (advance) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= item_next;
        end
    end

    tpi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpi_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .events  (events)
    );

    tpi_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .events   (events),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/tb_trackpad_report_inertia_core.sv =====
// Self-checking testbench for the trackpad report and glide engine, with its own behavioral predictor.
`timescale 1ns / 1ps

module tb_trackpad_report_inertia_core;
    import tpi_pkg::*;

    typedef struct packed {
        event_code_t             code;
        logic signed [AMT_W-1:0] amount;
        logic                    is_last;
    } engine_event_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [AMT_W-1:0]      m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    trackpad_report_inertia_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies used by the predictor.
    bit                  glide_en   = 1'b0;
    bit                  cursor_ok  = 1'b0;
    bit                  scroll_ok  = 1'b0;
    bit [FRICTION_W-1:0] friction   = FRICTION_RESET;
    bit [MIN_SPD_W-1:0]  lift_speed = MIN_SPEED_RESET;
    bit                  nat_x      = 1'b0;
    bit                  nat_y      = 1'b0;

    // Predicted engine state.
    logic signed [VEL_W-1:0] vel_x = '0;
    logic signed [VEL_W-1:0] vel_y = '0;
    logic signed [9:0]       frac_x = '0;
    logic signed [9:0]       frac_y = '0;
    logic signed [17:0]      whl_x = '0;
    logic signed [17:0]      whl_y = '0;
    glide_kind_t             glide_kind = GLIDE_NONE;
    bit                      armed = 1'b0;
    bit                      touch_prev = 1'b0;
    bit                      hold_down = 1'b0;

    item_t         pending_items[$];
    engine_event_t events_due[$];

    item_t cur_item;
    bit    item_loaded = 1'b0;
    int    gap_left = 0;
    int    stall_left = 0;
    bit    tx_idle_on = 1'b1;
    bit    rx_idle_on = 1'b1;

    int reports_queued = 0;
    int ticks_queued = 0;
    int events_checked = 0;
    int settings_used = 0;
    int mismatches = 0;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void add_event(event_code_t code, longint amt);
        engine_event_t ev;
        if (amt > 32767) begin
            amt = 32767;
        end else if (amt < -32768) begin
            amt = -32768;
        end
        ev.code    = code;
        ev.amount  = 16'(amt);
        ev.is_last = 1'b0;
        events_due.push_back(ev);
    endfunction

    // Accumulate into one wheel remainder; whole steps truncate toward zero.
    function automatic void wheel_add(bit vertical, longint delta);
        longint acc;
        acc = vertical ? longint'(whl_y) : longint'(whl_x);
        acc = acc + delta;
        if (mag(acc) >= WHEEL_DIV) begin
            add_event(event_code_t'(vertical ? EV_WHEEL : EV_HWHEEL), acc / WHEEL_DIV);
            acc = acc % WHEEL_DIV;
        end
        if (vertical) begin
            whl_y = 18'(acc);
        end else begin
            whl_x = 18'(acc);
        end
    endfunction

    function automatic void clear_glide();
        glide_kind = GLIDE_NONE;
        vel_x = '0;
        vel_y = '0;
    endfunction

    function automatic void glide_tick();
        longint fx, fy, sx, sy, vx, vy, fr;
        if (!armed) begin
            return;
        end
        if (glide_kind != GLIDE_CURSOR && glide_kind != GLIDE_SCROLL) begin
            armed = 1'b0;
            return;
        end
        fx = longint'(frac_x) + longint'(vel_x);
        fy = longint'(frac_y) + longint'(vel_y);
        sx = fx >>> 8;
        sy = fy >>> 8;
        frac_x = 10'(fx - sx * 256);
        frac_y = 10'(fy - sy * 256);
        if (glide_kind == GLIDE_CURSOR) begin
            if (sx != 0 || sy != 0) begin
                add_event(EV_CURSOR_X, sx);
                add_event(EV_CURSOR_Y, sy);
            end
        end else begin
            if (sx != 0) begin
                wheel_add(1'b0, sx);
            end
            if (sy != 0) begin
                wheel_add(1'b1, sy);
            end
        end
        fr = friction;
        vx = (longint'(vel_x) * fr) >>> 8;
        vy = (longint'(vel_y) * fr) >>> 8;
        vel_x = VEL_W'(vx);
        vel_y = VEL_W'(vy);
        if (mag(vx) < 256 && mag(vy) < 256) begin
            clear_glide();
            frac_x = '0;
            frac_y = '0;
            armed = 1'b0;
        end
    endfunction

    function automatic void take_report(item_t it);
        longint dx, dy, s, minq;
        bit     touching, armable;
        dx = longint'($signed(it.delta_x));
        dy = longint'($signed(it.delta_y));
        if (it.reset_seen) begin
            add_event(EV_RESET_ACK, 0);
            return;
        end
        if (!it.scroll_flag) begin
            whl_x = '0;
            whl_y = '0;
        end
        touching = (it.finger_count != 0);
        if (touching && !touch_prev) begin
            armed = 1'b0;
            clear_glide();
            frac_x = '0;
            frac_y = '0;
            whl_x = '0;
            whl_y = '0;
        end else if (!touching && touch_prev) begin
            armable = glide_en && ((glide_kind == GLIDE_CURSOR && cursor_ok) ||
                                   (glide_kind == GLIDE_SCROLL && scroll_ok));
            minq = lift_speed;
            minq = minq * 256;
            if (armable && (mag(vel_x) >= minq || mag(vel_y) >= minq)) begin
                frac_x = '0;
                frac_y = '0;
                armed = 1'b1;
            end else begin
                clear_glide();
            end
        end
        touch_prev = touching;

        if (it.hold_flag && !hold_down) begin
            add_event(EV_HOLD_PRESS, 0);
            hold_down = 1'b1;
            clear_glide();
        end else if (!it.hold_flag && hold_down) begin
            add_event(EV_HOLD_RELEAS, 0);
            hold_down = 1'b0;
            clear_glide();
        end else if (it.tap_one) begin
            add_event(EV_TAP_PRESS, 0);
        end else if (it.tap_two) begin
            add_event(EV_TAP_PRESS, 1);
        end else if (it.scroll_flag) begin
            // The horizontal axis wins whenever it moved.
            if (dx != 0) begin
                s = nat_x ? dx : -dx;
                wheel_add(1'b0, s);
                vel_x = VEL_W'((3 * longint'(vel_x) + s * 256) >>> 2);
                vel_y = VEL_W'((3 * longint'(vel_y)) >>> 2);
                glide_kind = GLIDE_SCROLL;
            end else if (dy != 0) begin
                s = nat_y ? -dy : dy;
                wheel_add(1'b1, s);
                vel_y = VEL_W'((3 * longint'(vel_y) + s * 256) >>> 2);
                vel_x = VEL_W'((3 * longint'(vel_x)) >>> 2);
                glide_kind = GLIDE_SCROLL;
            end
        end else if (it.moved_flag) begin
            if (dx != 0 || dy != 0) begin
                add_event(EV_CURSOR_X, dx);
                add_event(EV_CURSOR_Y, dy);
            end
            vel_x = VEL_W'((3 * longint'(vel_x) + dx * 256) >>> 2);
            vel_y = VEL_W'((3 * longint'(vel_y) + dy * 256) >>> 2);
            glide_kind = GLIDE_CURSOR;
        end
    endfunction

    function automatic void advance_engine(item_t it);
        int            n_before;
        engine_event_t ev;
        n_before = events_due.size();
        if (it.kind) begin
            glide_tick();
        end else begin
            take_report(it);
        end
        if (events_due.size() > n_before) begin
            ev = events_due.pop_back();
            ev.is_last = 1'b1;
            events_due.push_back(ev);
        end
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Report and tick driver.
    always @(posedge aclk) begin : report_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_engine(cur_item);
                item_loaded = 1'b0;
                gap_left = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
            end
            if (!item_loaded) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    item_loaded = 1'b1;
                end
            end
            s_tvalid <= item_loaded;
            s_tuser  <= cur_item.kind;
            s_tdata  <= {2'b00, cur_item.delta_y, cur_item.delta_x, cur_item.finger_count,
                         cur_item.moved_flag, cur_item.scroll_flag, cur_item.hold_flag,
                         cur_item.tap_two, cur_item.tap_one, cur_item.reset_seen};
        end
    end

    // Event monitor and output back-pressure.
    always @(posedge aclk) begin : event_monitor
        engine_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            events_checked++;
            if (events_due.size() == 0) begin
                report_mismatch($sformatf("unexpected event code %0d amount %0d last %0b",
                                          m_tuser, $signed(m_tdata), m_tlast));
            end else begin
                want = events_due.pop_front();
                if (m_tuser !== want.code || m_tdata !== want.amount ||
                    m_tlast !== want.is_last) begin
                    report_mismatch($sformatf(
                        "got code %0d amount %0d last %0b, expected code %0d amount %0d last %0b",
                        m_tuser, $signed(m_tdata), m_tlast,
                        want.code, want.amount, want.is_last));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len();
        end
        m_tready <= (stall_left == 0);
    end

    task automatic queue_report(bit rs, bit t1, bit t2, bit hold, bit scroll, bit moved,
                                logic [7:0] fingers, logic signed [15:0] dx,
                                logic signed [15:0] dy);
        item_t it;
        it.kind         = 1'b0;
        it.reset_seen   = rs;
        it.tap_one      = t1;
        it.tap_two      = t2;
        it.hold_flag    = hold;
        it.scroll_flag  = scroll;
        it.moved_flag   = moved;
        it.finger_count = fingers;
        it.delta_x      = dx;
        it.delta_y      = dy;
        pending_items.push_back(it);
        reports_queued++;
    endtask

    // A tick carries random junk in the fields it does not use.
    task automatic queue_tick();
        logic [63:0] junk;
        item_t       it;
        junk = {$urandom, $urandom};
        it = junk[46:0];
        it.kind = 1'b1;
        pending_items.push_back(it);
        ticks_queued++;
    endtask

    task automatic queue_noise();
        logic [63:0] junk;
        item_t       it;
        junk = {$urandom, $urandom};
        it = junk[46:0];
        it.kind = ($urandom_range(0, 3) == 0);
        it.reset_seen = ($urandom_range(0, 3) == 0);
        pending_items.push_back(it);
        if (it.kind) begin
            ticks_queued++;
        end else begin
            reports_queued++;
        end
    endtask

    function automatic logic signed [15:0] rand_delta();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 16'($signed($urandom_range(0, 80)) - 40);
        end else if (roll < 85) begin
            return 16'($signed($urandom_range(0, 1200)) - 600);
        end else if (roll < 95) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 2))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'sh0000;
        endcase
    endfunction

    // Touch, a run of moves or scrolls, a lift, then glide ticks; sometimes only random noise items.
    task automatic queue_gesture();
        int                 roll, steps, ticks;
        bit                 scrolling;
        logic signed [15:0] dx, dy;
        logic [7:0]         fingers;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            repeat ($urandom_range(1, 4)) queue_noise();
            return;
        end
        scrolling = ($urandom_range(0, 2) == 0);
        steps = $urandom_range(1, 8);
        for (int i = 0; i < steps; i++) begin
            dx = rand_delta();
            dy = rand_delta();
            if (scrolling && $urandom_range(0, 1)) begin
                dx = '0;
            end
            fingers = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) :
                                                    8'($urandom_range(1, 3));
            queue_report($urandom_range(0, 49) == 0, $urandom_range(0, 39) == 0,
                         $urandom_range(0, 39) == 0, $urandom_range(0, 29) == 0,
                         scrolling, !scrolling || $urandom_range(0, 1), fingers, dx, dy);
        end
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, scrolling && $urandom_range(0, 1),
                     $urandom_range(0, 1) == 1, 8'd0, rand_delta(), rand_delta());
        ticks = $urandom_range(0, 24);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                // A second lift, or a touch that cuts the glide short.
                queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 1) == 1,
                             $urandom_range(0, 1) ? 8'd0 : 8'd1, rand_delta(), rand_delta());
            end else begin
                queue_tick();
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GLIDE_ENABLE:   glide_en   = val[0];
            CFG_CURSOR_ALLOWED: cursor_ok  = val[0];
            CFG_SCROLL_ALLOWED: scroll_ok  = val[0];
            CFG_FRICTION:       friction   = val;
            CFG_MIN_SPEED:      lift_speed = val[MIN_SPD_W-1:0];
            CFG_NATURAL_X:      nat_x      = val[0];
            CFG_NATURAL_Y:      nat_y      = val[0];
            default: ;
        endcase
    endtask

    task automatic set_glide_config(bit en, bit cur, bit scr, logic [7:0] fric,
                                    logic [7:0] minspd, bit nx, bit ny);
        write_reg(CFG_GLIDE_ENABLE, {7'd0, en});
        write_reg(CFG_CURSOR_ALLOWED, {7'd0, cur});
        write_reg(CFG_SCROLL_ALLOWED, {7'd0, scr});
        write_reg(CFG_FRICTION, fric);
        write_reg(CFG_MIN_SPEED, minspd);
        write_reg(CFG_NATURAL_X, {7'd0, nx});
        write_reg(CFG_NATURAL_Y, {7'd0, ny});
        settings_used++;
    endtask

    // Wait until every queued word is sent and every event has come back,
    // then allow for items still in flight that produce nothing.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || item_loaded || events_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: glide off, both scroll axes in their default sense.
        settings_used = 1;
        queue_tick();
        queue_report(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 16'sh8000, 16'sh7FFF);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd1, 16'sh7FFF, 16'sh8000);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 16'sh0000, 16'sh0000);
        queue_report(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'd2, 16'sd5, 16'sd5);
        queue_report(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd2, 16'sd5, 16'sd5);
        queue_report(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'd2, 16'sd7, 16'sd7);
        queue_report(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'd2, 16'sd64, 16'sd0);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd2, 16'sd0, 16'sd0);
        // Exact negation of the most negative delta, then truncating wheel division.
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd2, 16'sh8000, 16'sd0);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd2, 16'sd0, -16'sd40);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd2, 16'sd0, -16'sd20);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd2, 16'sd0, -16'sd4);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        wait_drained();

        // Cursor glide, a hold that cancels it, then a scroll glide with a second lift.
        set_glide_config(1'b1, 1'b1, 1'b1, 8'd160, 8'd2, 1'b1, 1'b0);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd1, 16'sd2000, -16'sd3000);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd1, 16'sd2000, -16'sd3000);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_tick();
        queue_tick();
        queue_report(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_tick();
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd3, 16'sd0, -16'sd500);
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_tick();
        queue_report(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_tick();

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            tx_idle_on = (p != 2 && p != 4);
            rx_idle_on = (p != 3 && p != 4);
            case (p)
                0: set_glide_config(1'b1, 1'b1, 1'b1, 8'd242, 8'd2, 1'b0, 1'b0);
                1: set_glide_config(1'b1, 1'b1, 1'b1, 8'd160, 8'd0, 1'b1, 1'b1);
                2: set_glide_config(1'b1, 1'b1, 1'b0, 8'd252, 8'd60, 1'b0, 1'b1);
                3: set_glide_config(1'b1, 1'b0, 1'b1, 8'd255, 8'd1, 1'b1, 1'b0);
                4: set_glide_config(1'b1, 1'b1, 1'b1, 8'd0, 8'd63, 1'b1, 1'b1);
                default: set_glide_config(1'b0, 1'b1, 1'b1, 8'd200, 8'd0, 1'b0, 1'b0);
            endcase
            target = reports_queued + ticks_queued + 195;
            while (reports_queued + ticks_queued < target) begin
                queue_gesture();
            end
        end

        wait_drained();
        $display("Sent %0d reports and %0d glide ticks under %0d register settings;",
                 reports_queued, ticks_queued, settings_used);
        $display("checked %0d events, %0d mismatches.", events_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb_trackpad_report_inertia_core: done, clean");
        end else begin
            $display("tb_trackpad_report_inertia_core: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Timeout with %0d events still expected.", events_due.size());
        $display("tb_trackpad_report_inertia_core: done, errors");
        $finish;
    end

endmodule
